FILE: sv/fmbq_pkg.sv
`default_nettype none
package fmbq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int STS_W = 2;
  localparam int OCC_W = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_MID   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_POP_MID    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd5;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef enum logic [1:0] {ACT_NOP, ACT_INS, ACT_REM} act_t;
  typedef enum logic [1:0] {W_FRONT, W_MID, W_BACK} where_t;
  typedef enum logic {S_IDLE, S_RESP} state_t;

  typedef struct packed {
    logic               load;
    act_t               act;
    where_t             where;
    logic [STS_W-1:0]   rstat;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: sv/fmbq_if.sv
`default_nettype none
interface fmbq_in_if
  import fmbq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic        [REQ_W-1:0]  req_type;
  logic signed [VAL_W-1:0]  push_value;

  modport source (output valid, req_type, push_value, input ready);
  modport sink   (input valid, req_type, push_value, output ready);
endinterface

interface fmbq_out_if
  import fmbq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  pop_value;
  logic        [STS_W-1:0]  status;
  logic        [OCC_W-1:0]  occupancy;

  modport source (output valid, pop_value, status, occupancy, input ready);
  modport sink   (input valid, pop_value, status, occupancy, output ready);
endinterface
`default_nettype wire

FILE: sv/fmbq_ctrl.sv
`default_nettype none
module fmbq_ctrl
  import fmbq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [REQ_W-1:0] in_req_type,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dp_status_t       dp_status,
  output dp_cmd_t               dp_cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    dp_cmd.load  = 1'b0;
    dp_cmd.act   = ACT_NOP;
    dp_cmd.where = W_FRONT;
    dp_cmd.rstat = STS_OK;

    // decode request; only takes effect when load is set
    unique case (in_req_type) inside
      REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK: begin
        if (dp_status.full) begin
          dp_cmd.rstat = STS_FULL;
        end else begin
          dp_cmd.act = ACT_INS;
        end
      end
      REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK: begin
        if (dp_status.empty) begin
          dp_cmd.rstat = STS_EMPTY;
        end else begin
          dp_cmd.act = ACT_REM;
        end
      end
      default: begin
        dp_cmd.act = ACT_NOP;
      end
    endcase

    unique case (in_req_type) inside
      REQ_PUSH_MID, REQ_POP_MID:   dp_cmd.where = W_MID;
      REQ_PUSH_BACK, REQ_POP_BACK: dp_cmd.where = W_BACK;
      default:                     dp_cmd.where = W_FRONT;
    endcase

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_RESP;
        end
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load |-> state_r == S_IDLE)
    else $error("load outside idle");

  a_load_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load |=> out_valid)
    else $error("no response after load");

  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("accepting while result pending");

endmodule
`default_nettype wire

FILE: sv/fmbq_dp.sv
`default_nettype none
module fmbq_dp
  import fmbq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dp_cmd_t                 dp_cmd,
  input  wire logic signed [VAL_W-1:0] push_value,
  output dp_status_t                   dp_status,
  output logic signed [VAL_W-1:0]      pop_value,
  output logic        [STS_W-1:0]      status,
  output logic        [OCC_W-1:0]      occupancy
);

  logic        [VAL_W-1:0] cell_r [CAPACITY];
  logic        [VAL_W-1:0] cell_nxt [CAPACITY];
  logic        [CNT_W-1:0] count_r, count_nxt;
  logic signed [VAL_W-1:0] pop_r, pop_nxt;
  logic        [STS_W-1:0] sts_r;
  logic        [CNT_W-1:0] pos;
  logic        [CNT_W-1:0] count_m1;

  assign count_m1        = count_r - CNT_W'(1);
  assign dp_status.full  = (count_r == CNT_W'(CAPACITY));
  assign dp_status.empty = (count_r == '0);

  // insert index uses count, remove index uses count-1
  always_comb begin
    pos = '0;
    case (dp_cmd.where)
      W_MID:   pos = (dp_cmd.act == ACT_REM) ? (count_m1 >> 1) : (count_r >> 1);
      W_BACK:  pos = (dp_cmd.act == ACT_REM) ? count_m1 : count_r;
      default: pos = '0;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (dp_cmd.load && dp_cmd.act == ACT_INS) begin
        if (IDX == pos) begin
          cell_nxt[i] = push_value;
        end else if (IDX > pos && IDX <= count_r) begin
          cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
        end
      end else if (dp_cmd.load && dp_cmd.act == ACT_REM) begin
        if (IDX >= pos && (IDX + CNT_W'(1)) < count_r) begin
          cell_nxt[i] = cell_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    pop_nxt   = '0;
    case (dp_cmd.act)
      ACT_INS: count_nxt = count_r + CNT_W'(1);
      ACT_REM: begin
        count_nxt = count_m1;
        pop_nxt   = cell_r[pos[IDX_W-1:0]];
      end
      default: begin
        if (dp_cmd.rstat == STS_EMPTY) begin
          pop_nxt = '1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (dp_cmd.load) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      pop_r <= pop_nxt;
      sts_r <= dp_cmd.rstat;
    end
  end

  assign pop_value = pop_r;
  assign status    = sts_r;
  assign occupancy = OCC_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load && dp_cmd.act == ACT_INS |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow count");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load && dp_cmd.act == ACT_NOP |=> $stable(count_r))
    else $error("count moved on rejected transaction");

  a_rem_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.load && dp_cmd.act == ACT_REM |-> count_r != '0)
    else $error("remove from empty store");

endmodule
`default_nettype wire

FILE: sv/front_middle_back_queue_top.sv
`default_nettype none
// Front/middle/back queue of signed 32-bit values, 16 entries deep.
// in_ch carries one request per transaction: req_type selects push front,
// push middle, push back, pop front, pop middle or pop back; push_value is
// used by pushes only. out_ch returns exactly one result per request:
// pop_value (removed value, -1 on empty pop, 0 otherwise), status
// (ok, empty, full) and occupancy after the request.
// Entries are a row of registers; an insert or remove shifts all cells
// above the position in the same cycle the request is accepted.
// Latency: result is valid the cycle after the request is accepted.
// The controller alternates accept and respond, one request in flight.
// A stalled receiver holds the result; in_ch.ready stays low until the
// result is taken.
// Reset (synchronous rst_n low) empties the queue; cell contents are not
// cleared, only entries below the occupancy are ever read.
module front_middle_back_queue_top
  import fmbq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  fmbq_in_if.sink    in_ch,
  fmbq_out_if.source out_ch
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  fmbq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_req_type (in_ch.req_type),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .dp_status   (dp_status),
    .dp_cmd      (dp_cmd)
  );

  fmbq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .dp_cmd     (dp_cmd),
    .push_value (in_ch.push_value),
    .dp_status  (dp_status),
    .pop_value  (out_ch.pop_value),
    .status     (out_ch.status),
    .occupancy  (out_ch.occupancy)
  );

endmodule
`default_nettype wire

FILE: test/fmbq_checker.sv
`timescale 1ns / 100ps
module fmbq_checker
  import fmbq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic [REQ_W-1:0]   in_req_type,
  input  wire logic [VAL_W-1:0]   in_push_value,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic [VAL_W-1:0]   out_pop_value,
  input  wire logic [STS_W-1:0]   out_status,
  input  wire logic [OCC_W-1:0]   out_occupancy,
  output int                      outstanding,
  output int                      fail_count
);

  typedef struct packed {
    logic signed [VAL_W-1:0] pop_value;
    logic [STS_W-1:0]        status;
    logic [OCC_W-1:0]        occupancy;
  } queue_result_t;

  logic signed [VAL_W-1:0] cells [CAPACITY];
  int                      depth;
  queue_result_t           pending_results [$];
  queue_result_t           oldest;

  initial begin
    outstanding = 0;
    fail_count  = 0;
    depth       = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Applies one request to the shadow store and returns the result it should produce.
  function automatic queue_result_t queue_apply(input logic [REQ_W-1:0] req,
                                                input logic signed [VAL_W-1:0] val);
    queue_result_t res;
    int            pos;
    int            i;
    res = '0;
    pos = 0;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK: begin
        if (depth >= CAPACITY) begin
          res.status = STS_FULL;
        end else begin
          if (req == REQ_PUSH_MID) pos = depth / 2;
          else if (req == REQ_PUSH_BACK) pos = depth;
          for (i = depth; i > pos; i--) cells[i] = cells[i-1];
          cells[pos] = val;
          depth++;
        end
      end
      REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK: begin
        if (depth == 0) begin
          res.status    = STS_EMPTY;
          res.pop_value = -1;
        end else begin
          // even count: middle pop takes the left of the two center entries
          if (req == REQ_POP_MID) pos = (depth - 1) / 2;
          else if (req == REQ_POP_BACK) pos = depth - 1;
          res.pop_value = cells[pos];
          for (i = pos; i + 1 < depth; i++) cells[i] = cells[i+1];
          depth--;
        end
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(depth);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      depth = 0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready)
        pending_results = {pending_results, queue_apply(in_req_type, $signed(in_push_value))};
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with no request outstanding", $realtime);
          fail_count++;
        end else begin
          oldest = pending_results[0];
          pending_results.delete(0);
          if (out_pop_value !== oldest.pop_value)
            report_mismatch("pop_value", $signed(out_pop_value), oldest.pop_value);
          if (out_status !== oldest.status)
            report_mismatch("status", out_status, oldest.status);
          if (out_occupancy !== oldest.occupancy)
            report_mismatch("occupancy", out_occupancy, oldest.occupancy);
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

FILE: test/tb_front_middle_back_queue_top.sv
`timescale 1ns / 100ps
module tb_front_middle_back_queue_top;
  import fmbq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam int RANDOM_REQS  = 1030;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;

  logic clk;
  logic rst_n;
  logic idle_on;
  logic hold_sink;
  int   outstanding;
  int   fail_count;
  int   stall_cycles;

  fmbq_in_if  in_ch ();
  fmbq_out_if out_ch ();

  front_middle_back_queue_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fmbq_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_req_type   (in_ch.req_type),
    .in_push_value (in_ch.push_value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_pop_value (out_ch.pop_value),
    .out_status    (out_ch.status),
    .out_occupancy (out_ch.occupancy),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // no progress on either channel for too long means the block hung
  initial stall_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_sink = 1'b0;
      end else begin
        out_ch.ready <= rst_n && !(idle_on && $urandom_range(0, 99) < 10);
      end
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] req, input logic signed [VAL_W-1:0] val);
    if (idle_on && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= req;
    in_ch.push_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    logic [REQ_W-1:0]        push_ops [3];
    logic [REQ_W-1:0]        pop_ops  [3];
    logic [REQ_W-1:0]        req;
    logic signed [VAL_W-1:0] val;
    int                      n;
    int                      push_pct;
    int                      pick;

    push_ops = '{REQ_PUSH_FRONT, REQ_PUSH_MID, REQ_PUSH_BACK};
    pop_ops  = '{REQ_POP_FRONT, REQ_POP_MID, REQ_POP_BACK};
    idle_on   = 1'b1;
    hold_sink = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_PUSH_FRONT;
    in_ch.push_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pops, unused codes, extreme values, middle on both parities
    send_request(REQ_POP_FRONT, 32'sd5);
    send_request(REQ_POP_MID, 32'sd5);
    send_request(REQ_POP_BACK, 32'sd5);
    send_request(REQ_UNUSED_LO, 32'sh7FFF_FFFF);
    send_request(REQ_UNUSED_HI, -32'sd1);
    send_request(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_request(REQ_PUSH_BACK, 32'sh8000_0000);
    send_request(REQ_PUSH_MID, -32'sd1);
    send_request(REQ_PUSH_MID, 32'sd0);
    send_request(REQ_POP_MID, 32'sd0);
    send_request(REQ_POP_MID, 32'sd0);
    send_request(REQ_PUSH_FRONT, 32'sh5555_AAAA);
    send_request(REQ_POP_BACK, 32'sd0);
    send_request(REQ_POP_FRONT, 32'sd0);
    send_request(REQ_POP_MID, 32'sd0);
    send_request(REQ_POP_MID, 32'sd0);
    drain_results();

    // random: blocks alternate between fill-heavy, balanced and drain-heavy mixes
    n = 0;
    while (n < RANDOM_REQS) begin
      idle_on = !(n >= 300 && n < 600);
      if (n == 200 && !hold_sink) hold_sink = 1'b1;
      if (n == 700) drain_results();
      case ((n / 40) % 3)
        0:       push_pct = 85;
        1:       push_pct = 50;
        default: push_pct = 15;
      endcase
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       val = 32'sh7FFF_FFFF;
        1:       val = 32'sh8000_0000;
        2:       val = -32'sd1;
        default: val = $urandom;
      endcase
      if (pick < 2) begin
        req = ($urandom_range(0, 1) != 0) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
      end else begin
        if (pick < push_pct) req = push_ops[$urandom_range(0, 2)];
        else req = pop_ops[$urandom_range(0, 2)];
        n++;
      end
      send_request(req, val);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
